### sv/switch_change_reporter_macros.svh
// ----------------------------------------------------------------------------
// Switch change reporter assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SWITCH_CHANGE_REPORTER_MACROS_SVH
`define SWITCH_CHANGE_REPORTER_MACROS_SVH

// Same-cycle implication.
`define SCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/scr_pkg.sv
// ----------------------------------------------------------------------------
// Switch change reporter package
// Types and constants shared by the reporter modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int MAX_EVENTS   = 4;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int CNT_W        = 3;

  typedef logic [NUM_CHANNELS-1:0] chan_vec_t;

  localparam chan_vec_t LEVEL_RESET = 16'h0101;

  // func field codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic      func;
    chan_vec_t levels;
  } in_item_t;

  typedef struct packed {
    logic             event_valid;
    logic [CH_W-1:0]  channel;
    logic             pressed;
    logic [CNT_W-1:0] report_count;
    logic             last;
  } out_item_t;

  // Result of checking one channel
  typedef struct packed {
    logic            hit;
    logic            pressed;
    logic            wrap;
    logic [CH_W-1:0] ptr_nxt;
  } scan_res_t;

endpackage

`default_nettype wire

### sv/scr_ifs.sv
// ----------------------------------------------------------------------------
// Switch change reporter channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface scr_in_if;
  import scr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scr_out_if;
  import scr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/switch_change_reporter.sv
// A sample transaction is absorbed when accepted. A report transaction
//   scans one channel per cycle, unless a stall holds it, from the saved
//   pointer up to channel 15 or the event limit, then flushes the final result.
// Throughput: a sample every cycle while idle; a report holds off the input
//   until its closing result is emitted, including waits on a busy output slot.
// Reset: async active low; levels go to 0x0101, enables and pointer to zero.
// ----------------------------------------------------------------------------
// Switch change reporter
// Change-of-state detector with round-robin event reporting over 16 switches.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_change_reporter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire scr_pkg::chan_vec_t cfg_wdata_i,
  scr_in_if.sink                  in_i,
  scr_out_if.source               out_o
);
  import scr_pkg::*;

  `include "switch_change_reporter_macros.svh"

  state_e           state_q, state_d;
  chan_vec_t        en_q;
  chan_vec_t        cur_q, cur_d;
  chan_vec_t        rep_q, rep_d;
  logic [CH_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_vld_q, pend_vld_d;
  out_item_t        pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;

  scan_res_t        scan;
  logic             in_acc;
  logic             out_free;
  logic             stall;
  logic             done_max;
  logic [CNT_W-1:0] cnt_inc;

  // One channel examined per cycle, unless stalled, by the shared scan unit.
  scr_scan_unit u_scan (
    .en_i  (en_q),
    .cur_i (cur_q),
    .rep_i (rep_q),
    .ptr_i (ptr_q),
    .res_o (scan)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Output slot is free if empty or being drained this cycle.
  assign out_free = !out_vld_q || out_o.ready;
  // A new hit must push the held event out; wait if the slot is busy.
  assign stall    = scan.hit && pend_vld_q && !out_free;
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign done_max = scan.hit && (cnt_inc == CNT_W'(MAX_EVENTS));

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.data.func == FUNC_REPORT) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall && (done_max || scan.wrap)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath / output logic. The most recent event is held back in the
  // pending register until we know whether it is the last of the report.
  always_comb begin
    cur_d      = cur_q;
    rep_d      = rep_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.func == FUNC_SAMPLE) begin
            cur_d = (cur_q & ~en_q) | (in_i.data.levels & en_q);
          end else begin
            cnt_d      = '0;
            pend_vld_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          ptr_d = scan.ptr_nxt;
          if (scan.hit) begin
            rep_d[ptr_q] = cur_q[ptr_q];
            cnt_d        = cnt_inc;
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d          = 1'b1;
            pend_d.event_valid  = 1'b1;
            pend_d.channel      = ptr_q;
            pend_d.pressed      = scan.pressed;
            pend_d.report_count = cnt_inc;
            pend_d.last         = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            // Nothing changed: a single empty closing result.
            out_d      = '0;
            out_d.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      en_q       <= '0;
      cur_q      <= LEVEL_RESET;
      rep_q      <= LEVEL_RESET;
      ptr_q      <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      rep_q      <= rep_d;
      ptr_q      <= ptr_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) en_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Assertions
  `SCR_ASSERT_NOW(a_evt_count_nonzero, out_vld_q && out_q.event_valid,
    out_q.report_count != '0, "event result with zero report_count")
  `SCR_ASSERT_NEXT(a_report_starts_scan, in_acc && in_i.data.func == FUNC_REPORT,
    state_q == ST_SCAN, "report transaction did not start a scan")
  `SCR_ASSERT_NEXT(a_flush_emits_last, state_q == ST_FLUSH && out_free,
    state_q == ST_IDLE && out_vld_q && out_q.last, "flush did not emit a closing result")
  `SCR_ASSERT_NOW(a_count_bounded, state_q == ST_SCAN,
    cnt_q < CNT_W'(MAX_EVENTS), "scan running with event limit reached")

endmodule

`default_nettype wire

### sv/scr_scan_unit.sv
// ----------------------------------------------------------------------------
// Switch change reporter scan unit
// Checks the channel under the pointer for an unreported change.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_scan_unit (
  input  wire scr_pkg::chan_vec_t          en_i,
  input  wire scr_pkg::chan_vec_t          cur_i,
  input  wire scr_pkg::chan_vec_t          rep_i,
  input  wire logic [scr_pkg::CH_W-1:0]    ptr_i,
  output scr_pkg::scan_res_t               res_o
);
  import scr_pkg::*;

  always_comb begin
    res_o.hit     = en_i[ptr_i] & (cur_i[ptr_i] ^ rep_i[ptr_i]);
    res_o.pressed = ~cur_i[ptr_i];
    res_o.wrap    = (ptr_i == CH_W'(NUM_CHANNELS - 1));
    res_o.ptr_nxt = res_o.wrap ? '0 : ptr_i + CH_W'(1);
  end

endmodule

`default_nettype wire
